// File: rtl/core/xcfr_pkg.sv
// Shared types and constants of the XOR-checked frame receiver.
package xcfr_pkg;

    // Default largest frame body in bytes.
    localparam int MAX_BODY_DEF = 16;

    // Fixed field widths of the item channels.
    localparam int BYTE_W     = 8;
    localparam int MSG_LEN_W  = 5;
    localparam int BYTE_IDX_W = 4;
    localparam int S_TDATA_W  = 8;
    localparam int M_TDATA_W  = 32;

    // Operation codes carried on the input tuser bit.
    localparam logic OP_RX_BYTE = 1'b0;
    localparam logic OP_RESYNC  = 1'b1;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load_rx;
        logic advance;
    } xcfr_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic frame_ok;
        logic last_item;
    } xcfr_status_t;

endpackage

// File: rtl/core/xcfr_ctrl.sv
// Controller state machine of the XOR-checked frame receiver.
module xcfr_ctrl (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    input  xcfr_pkg::xcfr_status_t status,
    output xcfr_pkg::xcfr_cmd_t    cmd
);
    import xcfr_pkg::*;

    typedef enum logic [1:0] {
        ST_RX   = 2'b01,
        ST_EMIT = 2'b10
    } state_t;

    state_t state_reg;
    state_t state_next;

    // Handshake outputs follow the state directly.
    assign s_tready = (state_reg == ST_RX);
    assign m_tvalid = (state_reg == ST_EMIT);

    // Commands to the datapath.
    assign cmd.load_rx = s_tvalid && s_tready;
    assign cmd.advance = m_tvalid && m_tready && !status.last_item;

    // Next state: a frame with a good checksum is drained before the next item is taken.
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_RX: begin
                if (cmd.load_rx && status.frame_ok) begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (m_tready && status.last_item) begin
                    state_next = ST_RX;
                end
            end
            default: begin
                state_next = ST_RX;
            end
        endcase
    end

    // State register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_RX;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

// File: rtl/core/xcfr_datapath.sv
// Datapath of the XOR-checked frame receiver: frame parsing, body store and result fields.
module xcfr_datapath #(
    parameter int MAX_BODY = xcfr_pkg::MAX_BODY_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  xcfr_pkg::xcfr_cmd_t           cmd,
    output xcfr_pkg::xcfr_status_t        status,
    input  logic                          s_op,
    input  logic [xcfr_pkg::BYTE_W-1:0]   s_byte,
    output logic [xcfr_pkg::BYTE_W-1:0]     msg_id,
    output logic [xcfr_pkg::MSG_LEN_W-1:0]  frame_len,
    output logic [xcfr_pkg::BYTE_IDX_W-1:0] byte_index,
    output logic [xcfr_pkg::BYTE_W-1:0]     data_byte
);
    import xcfr_pkg::*;

    localparam int POS_W = $clog2(MAX_BODY + 4);
    localparam int LEN_W = $clog2(MAX_BODY + 1);
    localparam int IDX_W = (MAX_BODY > 1) ? $clog2(MAX_BODY) : 1;

    localparam logic [POS_W-1:0]  POS_ID   = POS_W'(1);
    localparam logic [POS_W-1:0]  POS_LEN  = POS_W'(2);
    localparam logic [POS_W-1:0]  POS_BODY = POS_W'(3);
    localparam logic [BYTE_W:0]   MAX_LEN  = (BYTE_W + 1)'(MAX_BODY);

    logic [POS_W-1:0]  pos_reg,   pos_next;
    logic [BYTE_W-1:0] id_reg,    id_next;
    logic [POS_W-1:0]  lp2_reg,   lp2_next;
    logic [BYTE_W-1:0] chk_reg,   chk_next;
    logic [IDX_W-1:0]  k_reg,     k_next;
    logic [BYTE_W-1:0] rd_data_reg;
    logic [BYTE_W-1:0] store [MAX_BODY];

    logic [POS_W-1:0]  pos_inc;
    logic              wr_en;
    logic [IDX_W-1:0]  wr_addr;
    logic              frame_ok;
    logic [LEN_W-1:0]  body_len;
    logic              empty_body;

    assign pos_inc = pos_reg + POS_W'(1);
    assign wr_addr = IDX_W'(pos_inc - POS_BODY);

    // Parse one received item according to its position in the frame.
    always_comb begin
        pos_next = pos_reg;
        id_next  = id_reg;
        lp2_next = lp2_reg;
        chk_next = chk_reg;
        wr_en    = 1'b0;
        frame_ok = 1'b0;
        if (s_op == OP_RESYNC) begin
            pos_next = '0;
        end else if (pos_inc == POS_ID) begin
            pos_next = pos_inc;
            id_next  = s_byte;
            chk_next = s_byte;
        end else if (pos_inc == POS_LEN) begin
            if ({1'b0, s_byte} > MAX_LEN) begin
                // An oversized length is the id of a fresh frame.
                pos_next = POS_ID;
                id_next  = s_byte;
                chk_next = s_byte;
            end else begin
                pos_next = pos_inc;
                lp2_next = POS_W'(s_byte) + POS_LEN;
                chk_next = chk_reg ^ s_byte;
            end
        end else if (pos_inc <= lp2_reg) begin
            pos_next = pos_inc;
            chk_next = chk_reg ^ s_byte;
            wr_en    = 1'b1;
        end else begin
            // Checksum byte closes the frame whether or not it matches.
            pos_next = '0;
            frame_ok = (s_byte == chk_reg);
        end
    end

    // Result counter: restarts on every accepted item, steps on each taken result but the last.
    always_comb begin
        k_next = k_reg;
        if (cmd.load_rx) begin
            k_next = '0;
        end else if (cmd.advance) begin
            k_next = k_reg + IDX_W'(1);
        end
    end

    assign body_len   = LEN_W'(lp2_reg - POS_LEN);
    assign empty_body = (body_len == '0);

    assign status.frame_ok  = frame_ok;
    assign status.last_item = empty_body || (LEN_W'(k_reg) == body_len - LEN_W'(1));

    // Result fields, all from registers.
    assign msg_id     = id_reg;
    assign frame_len  = MSG_LEN_W'(body_len);
    assign byte_index = BYTE_IDX_W'(k_reg);
    assign data_byte  = empty_body ? '0 : rd_data_reg;

    // Frame state registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg <= '0;
            id_reg  <= '0;
            lp2_reg <= '0;
            chk_reg <= '0;
            k_reg   <= '0;
        end else begin
            if (cmd.load_rx) begin
                pos_reg <= pos_next;
                id_reg  <= id_next;
                lp2_reg <= lp2_next;
                chk_reg <= chk_next;
            end
            k_reg <= k_next;
        end
    end

    // Body store: written by body bytes, read one entry ahead of the result counter.
    always_ff @(posedge aclk) begin
        if (cmd.load_rx && wr_en) begin
            store[wr_addr] <= s_byte;
        end
        rd_data_reg <= store[k_next];
    end

endmodule

// File: rtl/core/xor_checked_frame_receiver_top.sv
// Top level of the XOR-checked frame receiver.
//
// Usage: received serial bytes enter on the s_ stream, one byte per item, with
// s_tuser low; an item with s_tuser high resynchronises the parser to the start
// of a frame. A frame is an id byte, a length byte (0 to MAX_BODY), the body and
// an XOR checksum over id, length and body. A frame with a good checksum leaves
// on the m_ stream as one item per body byte, or one item for an empty body,
// with m_tlast on the final item. A frame with a bad checksum is dropped.
// Input items are taken back to back while no results are pending. The checksum
// item of a good frame is followed by its results from the next cycle on, one
// per cycle while m_tready is high, and s_tready stays low until the final
// result is taken; the result counter and the registered read port of the body
// store step through the body. While the receiver stalls, the current result
// is held and no input item is taken. Synchronous reset clears the frame
// position, id, length, checksum and result counter; the body store keeps its
// contents and needs no clearing.
module xor_checked_frame_receiver_top #(
    parameter int MAX_BODY = xcfr_pkg::MAX_BODY_DEF
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [xcfr_pkg::S_TDATA_W-1:0]   s_tdata,  // rx_byte[7:0]
    input  logic                             s_tuser,  // operation[0]
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [xcfr_pkg::M_TDATA_W-1:0]   m_tdata,  // msg_id[7:0], frame_len[12:8],
                                                       // byte_index[16:13], data_byte[24:17]
    output logic                             m_tlast
);
    import xcfr_pkg::*;

    localparam int M_USED_W = 2 * BYTE_W + MSG_LEN_W + BYTE_IDX_W;

    xcfr_cmd_t    cmd;
    xcfr_status_t status;

    logic [BYTE_W-1:0]     msg_id;
    logic [MSG_LEN_W-1:0]  frame_len;
    logic [BYTE_IDX_W-1:0] byte_index;
    logic [BYTE_W-1:0]     data_byte;

    // Controller.
    xcfr_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .status   (status),
        .cmd      (cmd)
    );

    // Datapath.
    xcfr_datapath #(
        .MAX_BODY (MAX_BODY)
    ) u_datapath (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cmd        (cmd),
        .status     (status),
        .s_op       (s_tuser),
        .s_byte     (s_tdata[BYTE_W-1:0]),
        .msg_id     (msg_id),
        .frame_len  (frame_len),
        .byte_index (byte_index),
        .data_byte  (data_byte)
    );

    // Pack the result fields, lowest field first.
    assign m_tdata = {{(M_TDATA_W - M_USED_W){1'b0}}, data_byte, byte_index, frame_len, msg_id};
    assign m_tlast = status.last_item;

endmodule

// File: bench/xcfr_frame_checker.sv
// Checker that predicts and compares the result items of the XOR-checked frame receiver.
`timescale 1ns / 1ps

module xcfr_frame_checker (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_tvalid,
    input  logic                           s_tready,
    input  logic [xcfr_pkg::S_TDATA_W-1:0] s_tdata,   // rx_byte[7:0]
    input  logic                           s_tuser,   // operation[0]
    input  logic                           m_tvalid,
    input  logic                           m_tready,
    input  logic [xcfr_pkg::M_TDATA_W-1:0] m_tdata,   // msg_id[7:0], frame_len[12:8],
                                                      // byte_index[16:13], data_byte[24:17]
    input  logic                           m_tlast,
    output int                             fault_count,
    output int                             pending_beats
);

    localparam int BODY_MAX = xcfr_pkg::MAX_BODY_DEF;

    // One result item as the receiver should emit it.
    typedef struct packed {
        logic [7:0] msg_id;
        logic [4:0] frame_len;
        logic [3:0] byte_index;
        logic [7:0] data_byte;
        logic       last;
    } frame_beat_t;

    // Parser state mirrored from the block.
    logic [4:0] frame_pos;
    logic [7:0] frame_id;
    logic [4:0] len_plus_two;
    logic [7:0] xor_acc;
    logic [7:0] body_mem [BODY_MAX];

    frame_beat_t awaiting_beats [$];

    initial begin
        fault_count   = 0;
        pending_beats = 0;
    end

    // Advance the parser by one input item and queue any results a good frame releases.
    task automatic parse_rx_item(input logic op, input logic [7:0] rx);
        int          body_len;
        frame_beat_t beat;
        if (op == xcfr_pkg::OP_RESYNC) begin
            frame_pos = '0;
            return;
        end
        frame_pos = frame_pos + 5'd1;
        if (frame_pos == 5'd1) begin
            frame_id = rx;
            xor_acc  = rx;
        end else if (frame_pos == 5'd2) begin
            // A length byte that is too large starts a new frame as its id.
            if (rx > BODY_MAX) begin
                frame_pos = 5'd1;
                frame_id  = rx;
                xor_acc   = rx;
            end else begin
                len_plus_two = rx[4:0] + 5'd2;
                xor_acc      = xor_acc ^ rx;
            end
        end else if (frame_pos <= len_plus_two) begin
            xor_acc = xor_acc ^ rx;
            if (int'(frame_pos) - 3 < BODY_MAX)
                body_mem[frame_pos - 5'd3] = rx;
        end else begin
            // Checksum byte: the frame ends here whether or not it matches.
            frame_pos = '0;
            if (rx == xor_acc) begin
                body_len = int'(len_plus_two) - 2;
                if (body_len > BODY_MAX)
                    body_len = BODY_MAX;
                if (body_len == 0) begin
                    beat.msg_id     = frame_id;
                    beat.frame_len  = '0;
                    beat.byte_index = '0;
                    beat.data_byte  = '0;
                    beat.last       = 1'b1;
                    awaiting_beats.push_back(beat);
                end
                for (int k = 0; k < body_len; k++) begin
                    beat.msg_id     = frame_id;
                    beat.frame_len  = 5'(body_len);
                    beat.byte_index = 4'(k);
                    beat.data_byte  = body_mem[k];
                    beat.last       = (k + 1 == body_len);
                    awaiting_beats.push_back(beat);
                end
            end
        end
    endtask

    // Compare one accepted result item against the oldest expected one.
    task automatic check_beat(input logic [xcfr_pkg::M_TDATA_W-1:0] data, input logic tlast);
        frame_beat_t want;
        if (awaiting_beats.size() == 0) begin
            $error("unexpected result item: tdata %h, tlast %b", data, tlast);
            fault_count++;
            return;
        end
        want = awaiting_beats.pop_front();
        if (data[7:0] !== want.msg_id) begin
            $error("msg_id: expected %0d, actual %0d", want.msg_id, data[7:0]);
            fault_count++;
        end
        if (data[12:8] !== want.frame_len) begin
            $error("frame_len: expected %0d, actual %0d", want.frame_len, data[12:8]);
            fault_count++;
        end
        if (data[16:13] !== want.byte_index) begin
            $error("byte_index: expected %0d, actual %0d", want.byte_index, data[16:13]);
            fault_count++;
        end
        if (data[24:17] !== want.data_byte) begin
            $error("data_byte: expected %0d, actual %0d", want.data_byte, data[24:17]);
            fault_count++;
        end
        if (tlast !== want.last) begin
            $error("last: expected %0d, actual %0d", want.last, tlast);
            fault_count++;
        end
    endtask

    // Watch both channels at each rising edge.
    always @(posedge aclk) begin
        if (!aresetn) begin
            frame_pos    = '0;
            frame_id     = '0;
            len_plus_two = '0;
            xor_acc      = '0;
            awaiting_beats.delete();
        end else begin
            if (m_tvalid && m_tready)
                check_beat(m_tdata, m_tlast);
            if (s_tvalid && s_tready)
                parse_rx_item(s_tuser, s_tdata);
        end
        pending_beats = awaiting_beats.size();
    end

endmodule

// File: bench/tb_top.sv
// Testbench top of the XOR-checked frame receiver: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps

module tb_top;

    localparam int BODY_MAX    = xcfr_pkg::MAX_BODY_DEF;
    localparam int TOTAL_ITEMS = 400;
    localparam int CALM_FROM   = 330;

    logic                           aclk;
    logic                           aresetn;
    logic                           s_tvalid;
    logic                           s_tready;
    logic [xcfr_pkg::S_TDATA_W-1:0] s_tdata;   // rx_byte[7:0]
    logic                           s_tuser;   // operation[0]
    logic                           m_tvalid;
    logic                           m_tready;
    logic [xcfr_pkg::M_TDATA_W-1:0] m_tdata;   // msg_id[7:0], frame_len[12:8],
                                               // byte_index[16:13], data_byte[24:17]
    logic                           m_tlast;

    int fault_count;
    int pending_beats;
    int items_sent;
    bit quiet_tail;

    xor_checked_frame_receiver_top dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    xcfr_frame_checker frame_check (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_tvalid      (s_tvalid),
        .s_tready      (s_tready),
        .s_tdata       (s_tdata),
        .s_tuser       (s_tuser),
        .m_tvalid      (m_tvalid),
        .m_tready      (m_tready),
        .m_tdata       (m_tdata),
        .m_tlast       (m_tlast),
        .fault_count   (fault_count),
        .pending_beats (pending_beats)
    );

    // 12 ns clock.
    always begin
        aclk = 1'b0;
        #6;
        aclk = 1'b1;
        #6;
    end

    // Hang guard.
    initial begin
        #12_000_000;
        $display("FAIL");
        $finish;
    end

    // Result side: random stalls, occasional long ready stretches, none in the tail.
    initial begin
        m_tready = 1'b0;
        @(posedge aresetn);
        forever begin
            @(negedge aclk);
            if (!quiet_tail && $urandom_range(0, 5) == 0) begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 14)) @(negedge aclk);
            end else if ($urandom_range(0, 40) == 0) begin
                m_tready <= 1'b1;
                repeat ($urandom_range(20, 60)) @(negedge aclk);
            end
            m_tready <= 1'b1;
        end
    end

    // Present one item, after an optional gap, and wait for it to be taken.
    task automatic send_item(input logic op, input logic [7:0] rx);
        if (!quiet_tail && $urandom_range(0, 4) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 14)) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= rx;
        do @(posedge aclk); while (!s_tready);
        @(negedge aclk);
        items_sent++;
        if (items_sent >= CALM_FROM)
            quiet_tail = 1'b1;
    endtask

    // Send a frame with random body; the id may already have gone out.
    task automatic send_frame(input logic [7:0] id, input int body_len, input bit id_sent,
                              input bit spoil);
        logic [7:0] chk;
        logic [7:0] b;
        chk = id ^ 8'(body_len);
        if (!id_sent)
            send_item(xcfr_pkg::OP_RX_BYTE, id);
        send_item(xcfr_pkg::OP_RX_BYTE, 8'(body_len));
        for (int k = 0; k < body_len; k++) begin
            b   = 8'($urandom_range(0, 255));
            chk = chk ^ b;
            send_item(xcfr_pkg::OP_RX_BYTE, b);
        end
        if (spoil)
            chk = chk ^ 8'($urandom_range(1, 255));
        send_item(xcfr_pkg::OP_RX_BYTE, chk);
    endtask

    // Stimulus and verdict.
    initial begin
        int         choice;
        int         len;
        int         cut;
        logic [7:0] id;
        aresetn    = 1'b0;
        s_tvalid   = 1'b0;
        s_tdata    = '0;
        s_tuser    = xcfr_pkg::OP_RX_BYTE;
        items_sent = 0;
        quiet_tail = 1'b0;
        repeat (7) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Empty body with the largest id.
        send_item(xcfr_pkg::OP_RX_BYTE, 8'hFF);
        send_item(xcfr_pkg::OP_RX_BYTE, 8'h00);
        send_item(xcfr_pkg::OP_RX_BYTE, 8'hFF);
        // Length byte just above the limit becomes the id of a new frame.
        send_item(xcfr_pkg::OP_RX_BYTE, 8'h12);
        send_item(xcfr_pkg::OP_RX_BYTE, 8'h11);
        send_item(xcfr_pkg::OP_RX_BYTE, 8'h01);
        send_item(xcfr_pkg::OP_RX_BYTE, 8'hFF);
        send_item(xcfr_pkg::OP_RX_BYTE, 8'hEF);
        // Smallest id with extreme body bytes.
        send_item(xcfr_pkg::OP_RX_BYTE, 8'h00);
        send_item(xcfr_pkg::OP_RX_BYTE, 8'h02);
        send_item(xcfr_pkg::OP_RX_BYTE, 8'h00);
        send_item(xcfr_pkg::OP_RX_BYTE, 8'hFF);
        send_item(xcfr_pkg::OP_RX_BYTE, 8'hFD);
        // Checksum mismatch: the frame is dropped.
        send_item(xcfr_pkg::OP_RX_BYTE, 8'h80);
        send_item(xcfr_pkg::OP_RX_BYTE, 8'h00);
        send_item(xcfr_pkg::OP_RX_BYTE, 8'h7F);
        // Resync in the middle of a body, then a clean empty frame.
        send_item(xcfr_pkg::OP_RX_BYTE, 8'h33);
        send_item(xcfr_pkg::OP_RX_BYTE, 8'h03);
        send_item(xcfr_pkg::OP_RX_BYTE, 8'h44);
        send_item(xcfr_pkg::OP_RESYNC, 8'hFF);
        send_item(xcfr_pkg::OP_RX_BYTE, 8'h00);
        send_item(xcfr_pkg::OP_RX_BYTE, 8'h00);
        send_item(xcfr_pkg::OP_RX_BYTE, 8'h00);

        // Mostly good frames; some spoilt, oversized, cut short or noisy.
        while (items_sent < TOTAL_ITEMS) begin
            choice = $urandom_range(0, 19);
            len    = ($urandom_range(0, 6) == 0) ? BODY_MAX : $urandom_range(0, BODY_MAX);
            id     = 8'($urandom_range(0, 255));
            if (choice < 12) begin
                send_frame(id, len, 1'b0, 1'b0);
            end else if (choice < 14) begin
                send_frame(id, len, 1'b0, 1'b1);
            end else if (choice < 16) begin
                // One or more oversized length bytes; the last one is the real id.
                send_item(xcfr_pkg::OP_RX_BYTE, id);
                repeat ($urandom_range(1, 3)) begin
                    id = 8'($urandom_range(BODY_MAX + 1, 255));
                    send_item(xcfr_pkg::OP_RX_BYTE, id);
                end
                send_frame(id, len, 1'b1, $urandom_range(0, 3) == 0);
            end else if (choice < 17) begin
                send_item(xcfr_pkg::OP_RESYNC, 8'($urandom_range(0, 255)));
            end else if (choice < 19) begin
                // Frame cut short before its checksum, then resync.
                cut = $urandom_range(1, len + 2);
                send_item(xcfr_pkg::OP_RX_BYTE, id);
                if (cut >= 2)
                    send_item(xcfr_pkg::OP_RX_BYTE, 8'(len));
                repeat (cut - 2)
                    send_item(xcfr_pkg::OP_RX_BYTE, 8'($urandom_range(0, 255)));
                send_item(xcfr_pkg::OP_RESYNC, 8'($urandom_range(0, 255)));
            end else begin
                // Line noise, then resync.
                repeat ($urandom_range(1, 5))
                    send_item(xcfr_pkg::OP_RX_BYTE, 8'($urandom_range(0, 255)));
                send_item(xcfr_pkg::OP_RESYNC, 8'($urandom_range(0, 255)));
            end
        end
        s_tvalid <= 1'b0;

        // Drain outstanding results, then allow for any stray ones.
        while (pending_beats != 0) @(negedge aclk);
        repeat (40) @(negedge aclk);
        if (fault_count == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
